// ===== hdl/pie_pkg.sv =====
package pie_pkg;

    // Matrix geometry and fixed point format.
    localparam int MATRIX_DIM = 3;
    localparam int FRAC_BITS  = 16;
    localparam int NELEM      = MATRIX_DIM * MATRIX_DIM;
    localparam int IDX_W      = 2;
    localparam int ELEM_W     = 4;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 64;
    localparam int ACC_W      = 50;
    localparam int QUOT_W     = FRAC_BITS + 1;
    localparam int STEP_W     = 5;
    localparam int ITER_W     = 8;

    localparam logic [ITER_W-1:0] ITER_RESET = 8'd100;
    localparam logic signed [DATA_W-1:0] ONE_FX = 32'sh0001_0000;
    localparam logic signed [ACC_W-1:0] SAT_HI = 50'sh0_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT_LO = -50'sh0_0000_8000_0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             store_en;
        logic             run_init;
        logic             pass_init;
        logic             mul_en;
        logic             acc_en;
        logic             acc_last;
        logic             check_en;
        logic             div_load;
        logic             div_step;
        logic             div_write;
        logic             out_load;
        logic             degen;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } pie_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic best_zero;
        logic out_full;
    } pie_sts_t;

    // Magnitude of a signed word as an unsigned word; the most negative value maps to 2^31.
    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
        mag32 = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    endfunction

endpackage

// ===== hdl/power_iteration_dominant_eigen.sv =====
// Dominant eigenvalue of a 3x3 signed Q16.16 matrix by power iteration.
// Input channel (in_valid/in_ready): each word writes one matrix element at
// element_index (row*3+column); indexes of 9 and up store nothing. A word with
// go set starts a run from the vector (1,1,1) after its element is stored.
// Output channel (out_valid/out_ready): one word per run with lambda, the
// vector, and the saturated and degenerate flags. Words without go give none.
// Words are taken one per cycle while the block is idle, also while a result
// waits in the output register. A run blocks the input until it has ended.
// One pass runs nine multiply/accumulate pairs, a check, and for each
// component a 17-step restoring division plus load and write; the serial
// divider takes most of a pass. A run makes iteration_count passes;
// a zero lambda ends it early.
// When the receiver stalls, a finished run waits until the output register
// is free. Reset clears the controller and the output valid flag, sets the
// vector to ones and iteration_count to 100; the matrix is undefined until
// written. iteration_count is written over the APB port at any address.
module power_iteration_dominant_eigen (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [1:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [pie_pkg::DATA_W-1:0] element_value,
    input  logic [pie_pkg::ELEM_W-1:0]        element_index,
    input  logic                              go,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [pie_pkg::DATA_W-1:0] lambda_value,
    output logic signed [pie_pkg::DATA_W-1:0] vector_x0,
    output logic signed [pie_pkg::DATA_W-1:0] vector_x1,
    output logic signed [pie_pkg::DATA_W-1:0] vector_x2,
    output logic                              saturated,
    output logic                              degenerate
);
    import pie_pkg::*;

    logic [ITER_W-1:0] iter_reg;
    logic              cfg_wr;
    pie_cmd_t          cmd;
    pie_sts_t          sts;

    // Configuration register; the single register decodes every address.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = {{(32-ITER_W){1'b0}}, iter_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= ITER_RESET;
        end
        else if (cfg_wr)
        begin
            iter_reg <= pwdata[ITER_W-1:0];
        end
    end

    pie_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .go              (go),
        .iteration_count (iter_reg),
        .sts             (sts),
        .in_ready        (in_ready),
        .cmd             (cmd)
    );

    pie_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .element_value (element_value),
        .element_index (element_index),
        .out_ready     (out_ready),
        .sts           (sts),
        .out_valid     (out_valid),
        .lambda_value  (lambda_value),
        .vector_x0     (vector_x0),
        .vector_x1     (vector_x1),
        .vector_x2     (vector_x2),
        .saturated     (saturated),
        .degenerate    (degenerate)
    );

    // A degenerate run always reports a zero lambda.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> lambda_value == '0)
        else $error("degenerate result with nonzero lambda");

    // Normalized components never exceed 1.0 in magnitude.
    a_vec_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (vector_x0 <= ONE_FX) && (vector_x0 >= -ONE_FX)
                   && (vector_x1 <= ONE_FX) && (vector_x1 >= -ONE_FX)
                   && (vector_x2 <= ONE_FX) && (vector_x2 >= -ONE_FX))
        else $error("vector component beyond unit magnitude");

    // A new result is loaded only into an empty output register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid)
        else $error("result loaded over a pending word");

endmodule

// ===== hdl/pie_ctrl.sv =====
module pie_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     go,
    input  logic [pie_pkg::ITER_W-1:0] iteration_count,
    input  pie_pkg::pie_sts_t        sts,
    output logic                     in_ready,
    output pie_pkg::pie_cmd_t        cmd
);
    import pie_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_ACC    = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_DLOAD  = 3'd4;
    localparam logic [2:0] S_DSTEP  = 3'd5;
    localparam logic [2:0] S_DWRITE = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MATRIX_DIM - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [ITER_W-1:0] pass_reg, pass_next;
    logic              degen_reg, degen_next;
    logic              accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Sequencer: products and sums row by row, then one division per component.
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        step_next  = step_reg;
        pass_next  = pass_reg;
        degen_next = degen_reg;
        cmd        = '0;
        cmd.row    = row_reg;
        cmd.col    = col_reg;
        cmd.degen  = degen_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.store_en = accept;
                if (accept && go)
                begin
                    cmd.run_init  = 1'b1;
                    cmd.pass_init = 1'b1;
                    pass_next     = '0;
                    degen_next    = 1'b0;
                    row_next      = '0;
                    col_next      = '0;
                    state_next    = (iteration_count == '0) ? S_FINISH : S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_en   = 1'b1;
                cmd.acc_last = (col_reg == LAST_IDX);
                if (col_reg != LAST_IDX)
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    col_next = '0;
                    if (row_reg != LAST_IDX)
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        row_next   = '0;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                cmd.check_en = 1'b1;
                if (sts.best_zero)
                begin
                    degen_next = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_DLOAD;
                end
            end
            S_DLOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_DWRITE;
                end
            end
            S_DWRITE:
            begin
                cmd.div_write = 1'b1;
                if (row_reg != LAST_IDX)
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = S_DLOAD;
                end
                else
                begin
                    row_next  = '0;
                    pass_next = pass_reg + 1'b1;
                    if (pass_reg + 1'b1 == iteration_count)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.pass_init = 1'b1;
                        state_next    = S_MUL;
                    end
                end
            end
            S_FINISH:
            begin
                if (!sts.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            step_reg  <= '0;
            pass_reg  <= '0;
            degen_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            step_reg  <= step_next;
            pass_reg  <= pass_next;
            degen_reg <= degen_next;
        end
    end

endmodule

// ===== hdl/pie_datapath.sv =====
module pie_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pie_pkg::pie_cmd_t                 cmd,
    input  logic signed [pie_pkg::DATA_W-1:0] element_value,
    input  logic [pie_pkg::ELEM_W-1:0]        element_index,
    input  logic                              out_ready,
    output pie_pkg::pie_sts_t                 sts,
    output logic                              out_valid,
    output logic signed [pie_pkg::DATA_W-1:0] lambda_value,
    output logic signed [pie_pkg::DATA_W-1:0] vector_x0,
    output logic signed [pie_pkg::DATA_W-1:0] vector_x1,
    output logic signed [pie_pkg::DATA_W-1:0] vector_x2,
    output logic                              saturated,
    output logic                              degenerate
);
    import pie_pkg::*;

    logic signed [DATA_W-1:0] mat_reg [NELEM];
    logic signed [DATA_W-1:0] x_reg [MATRIX_DIM];
    logic signed [DATA_W-1:0] y_reg [MATRIX_DIM];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DATA_W-1:0] best_reg;
    logic                     sat_reg;
    logic [DATA_W-1:0]        dvs_reg;
    logic [DATA_W-1:0]        rem_reg;
    logic [QUOT_W-1:0]        num_reg;
    logic [QUOT_W-1:0]        quot_reg;
    logic                     neg_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] lam_out_reg, x0_out_reg, x1_out_reg, x2_out_reg;
    logic                     sat_out_reg, degen_out_reg;

    logic [ELEM_W-1:0]        mat_idx;
    logic signed [PROD_W-1:0] shifted;
    logic signed [ACC_W-1:0]  sum;
    logic signed [DATA_W-1:0] y_sat;
    logic                     clamp;
    logic [DATA_W-1:0]        y_mag;
    logic [DATA_W:0]          trial;
    logic signed [DATA_W-1:0] quot_signed;

    assign mat_idx = ELEM_W'(cmd.row) * ELEM_W'(MATRIX_DIM) + ELEM_W'(cmd.col);

    // Floor shift of the product and saturation of the finished row sum.
    always_comb
    begin
        shifted = prod_reg >>> FRAC_BITS;
        sum     = acc_reg + ACC_W'(shifted);
        clamp   = 1'b0;
        if (sum > SAT_HI)
        begin
            y_sat = DATA_W'(SAT_HI);
            clamp = 1'b1;
        end
        else if (sum < SAT_LO)
        begin
            y_sat = DATA_W'(SAT_LO);
            clamp = 1'b1;
        end
        else
        begin
            y_sat = DATA_W'(sum);
        end
    end

    // One restoring division step on the magnitudes.
    assign y_mag       = mag32(y_reg[cmd.row]);
    assign trial       = {rem_reg, num_reg[QUOT_W-1]} - {1'b0, dvs_reg};
    assign quot_signed = neg_reg ? -DATA_W'(quot_reg) : DATA_W'(quot_reg);

    // Matrix store, written by each accepted word with an index in range.
    always_ff @(posedge clk)
    begin
        if (cmd.store_en && (element_index < ELEM_W'(NELEM)))
        begin
            mat_reg[element_index] <= element_value;
        end
    end

    // Row sums, lambda search, saturation flag and the write of each divided component.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MATRIX_DIM; i++)
            begin
                x_reg[i] <= ONE_FX;
            end
            best_reg <= '0;
            sat_reg  <= 1'b0;
            acc_reg  <= '0;
        end
        else
        begin
            if (cmd.run_init)
            begin
                for (int i = 0; i < MATRIX_DIM; i++)
                begin
                    x_reg[i] <= ONE_FX;
                end
                sat_reg <= 1'b0;
            end
            if (cmd.pass_init)
            begin
                best_reg <= '0;
                acc_reg  <= '0;
            end
            if (cmd.acc_en)
            begin
                if (cmd.acc_last)
                begin
                    acc_reg <= '0;
                    if (clamp)
                    begin
                        sat_reg <= 1'b1;
                    end
                    if (mag32(best_reg) < mag32(y_sat))
                    begin
                        best_reg <= y_sat;
                    end
                end
                else
                begin
                    acc_reg <= sum;
                end
            end
            if (cmd.div_write)
            begin
                x_reg[cmd.row] <= quot_signed;
            end
        end
    end

    // Payload registers of the row sums, the multiplier and the divider.
    always_ff @(posedge clk)
    begin
        if (cmd.acc_en && cmd.acc_last)
        begin
            y_reg[cmd.row] <= y_sat;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'(mat_reg[mat_idx]) * PROD_W'(x_reg[cmd.col]);
        end
        if (cmd.check_en)
        begin
            dvs_reg <= mag32(best_reg);
        end
        if (cmd.div_load)
        begin
            rem_reg  <= y_mag >> 1;
            num_reg  <= {y_mag[0], {(QUOT_W-1){1'b0}}};
            quot_reg <= '0;
            neg_reg  <= y_reg[cmd.row][DATA_W-1];
        end
        else if (cmd.div_step)
        begin
            num_reg <= num_reg << 1;
            if (!trial[DATA_W])
            begin
                rem_reg  <= trial[DATA_W-1:0];
                quot_reg <= {quot_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= {rem_reg[DATA_W-2:0], num_reg[QUOT_W-1]};
                quot_reg <= {quot_reg[QUOT_W-2:0], 1'b0};
            end
        end
    end

    // Result register; holds until the receiver takes the word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            lam_out_reg   <= best_reg;
            x0_out_reg    <= x_reg[0];
            x1_out_reg    <= x_reg[1];
            x2_out_reg    <= x_reg[2];
            sat_out_reg   <= sat_reg;
            degen_out_reg <= cmd.degen;
        end
    end

    assign sts.best_zero = (best_reg == '0);
    assign sts.out_full  = out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign lambda_value  = lam_out_reg;
    assign vector_x0     = x0_out_reg;
    assign vector_x1     = x1_out_reg;
    assign vector_x2     = x2_out_reg;
    assign saturated     = sat_out_reg;
    assign degenerate    = degen_out_reg;

endmodule
